// File: hdl/icp_pkg.sv
// ============================================================================
// icp_pkg: shared types for the incircle predicate pipeline
// Result record handed from the determinant stages to the output port.
// ============================================================================
`default_nettype none

package icp_pkg;

  // Output stream data width (two flag bits padded to a byte)
  localparam int OUT_TDATA_W = 8;

  // One predicate result
  typedef struct packed {
    logic ends_swapped;
    logic passes;
  } icp_result_t;

endpackage

`default_nettype wire

// File: hdl/icp_orient.sv
// ============================================================================
// icp_orient: orientation test and edge reordering (two register stages)
// Stage 1 forms the two orientation products, stage 2 takes their sign,
// swaps the edge ends on a clockwise turn and forms differences to the probe.
// ============================================================================
`default_nettype none

module icp_orient #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [8*COORD_WIDTH-1:0]     in_coords,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_swapped,
  output logic signed [COORD_WIDTH:0]  out_ax,
  output logic signed [COORD_WIDTH:0]  out_ay,
  output logic signed [COORD_WIDTH:0]  out_bx,
  output logic signed [COORD_WIDTH:0]  out_by,
  output logic signed [COORD_WIDTH:0]  out_qx,
  output logic signed [COORD_WIDTH:0]  out_qy
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 2;   // orientation product width
  localparam int OW = 2 * W + 3;   // orientation value width

  // Sign-extended input coordinates
  logic signed [W:0] sx, sy, ex, ey, cx, cy, px, py;

  assign sx = $signed({in_coords[1*W-1], in_coords[0*W +: W]});
  assign sy = $signed({in_coords[2*W-1], in_coords[1*W +: W]});
  assign ex = $signed({in_coords[3*W-1], in_coords[2*W +: W]});
  assign ey = $signed({in_coords[4*W-1], in_coords[3*W +: W]});
  assign cx = $signed({in_coords[5*W-1], in_coords[4*W +: W]});
  assign cy = $signed({in_coords[6*W-1], in_coords[5*W +: W]});
  assign px = $signed({in_coords[7*W-1], in_coords[6*W +: W]});
  assign py = $signed({in_coords[8*W-1], in_coords[7*W +: W]});

  // Stage registers
  logic              v1, v2;
  logic              ready1, ready2;
  logic signed [W:0] s1_sx, s1_sy, s1_ex, s1_ey, s1_cx, s1_cy, s1_px, s1_py;
  logic signed [PW-1:0] op1, op2;
  logic signed [W:0] d_ey_sy, d_cx_ex, d_ex_sx, d_cy_ey;

  // Advance a stage when it is empty or its content moves on
  assign ready2   = !v2 || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  assign d_ey_sy = ey - sy;
  assign d_cx_ex = cx - ex;
  assign d_ex_sx = ex - sx;
  assign d_cy_ey = cy - ey;

  // Stage 1: orientation products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_sx <= sx;
      s1_sy <= sy;
      s1_ex <= ex;
      s1_ey <= ey;
      s1_cx <= cx;
      s1_cy <= cy;
      s1_px <= px;
      s1_py <= py;
      op1   <= PW'(d_ey_sy) * PW'(d_cx_ex);
      op2   <= PW'(d_ex_sx) * PW'(d_cy_ey);
    end
  end

  // Stage 2: orientation sign, reorder, differences to the probe
  logic signed [OW-1:0] orient;
  logic                 swap;
  logic signed [W:0]    a_x, a_y, b_x, b_y;

  assign orient = OW'(op1) - OW'(op2);
  assign swap   = !orient[OW-1] && (orient != '0);
  assign a_x    = swap ? s1_ex : s1_sx;
  assign a_y    = swap ? s1_ey : s1_sy;
  assign b_x    = swap ? s1_sx : s1_ex;
  assign b_y    = swap ? s1_sy : s1_ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      out_swapped <= swap;
      out_ax      <= a_x - s1_px;
      out_ay      <= a_y - s1_py;
      out_bx      <= b_x - s1_px;
      out_by      <= b_y - s1_py;
      out_qx      <= s1_cx - s1_px;
      out_qy      <= s1_cy - s1_py;
    end
  end

  assign out_valid = v2;

endmodule

`default_nettype wire

// File: hdl/icp_lift.sv
// ============================================================================
// icp_lift: lifted terms and 2x2 minors (one register stage)
// Forms the squared distances to the probe and the three cofactor minors.
// ============================================================================
`default_nettype none

module icp_lift #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_swapped,
  input  logic signed [COORD_WIDTH:0]   in_ax,
  input  logic signed [COORD_WIDTH:0]   in_ay,
  input  logic signed [COORD_WIDTH:0]   in_bx,
  input  logic signed [COORD_WIDTH:0]   in_by,
  input  logic signed [COORD_WIDTH:0]   in_qx,
  input  logic signed [COORD_WIDTH:0]   in_qy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_swapped,
  output logic [2*COORD_WIDTH+1:0]      out_la,
  output logic [2*COORD_WIDTH+1:0]      out_lb,
  output logic [2*COORD_WIDTH+1:0]      out_lc,
  output logic signed [2*COORD_WIDTH+2:0] out_ca,
  output logic signed [2*COORD_WIDTH+2:0] out_cb,
  output logic signed [2*COORD_WIDTH+2:0] out_cc
);

  localparam int LW = 2 * COORD_WIDTH + 2;   // lifted term width (unsigned)
  localparam int CW = 2 * COORD_WIDTH + 3;   // minor width (signed)

  logic v3;
  logic ready3;

  logic signed [LW-1:0] la_s, lb_s, lc_s;
  logic signed [CW-1:0] ca_s, cb_s, cc_s;

  assign ready3   = !v3 || out_ready;
  assign in_ready = ready3;

  // Squared distances are never negative and fit the lifted term width
  assign la_s = LW'(in_ax) * LW'(in_ax) + LW'(in_ay) * LW'(in_ay);
  assign lb_s = LW'(in_bx) * LW'(in_bx) + LW'(in_by) * LW'(in_by);
  assign lc_s = LW'(in_qx) * LW'(in_qx) + LW'(in_qy) * LW'(in_qy);

  // Minors of the remaining 2x2 blocks
  assign ca_s = CW'(in_bx) * CW'(in_qy) - CW'(in_qx) * CW'(in_by);
  assign cb_s = CW'(in_qx) * CW'(in_ay) - CW'(in_ax) * CW'(in_qy);
  assign cc_s = CW'(in_ax) * CW'(in_by) - CW'(in_bx) * CW'(in_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      out_swapped <= in_swapped;
      out_la      <= la_s;
      out_lb      <= lb_s;
      out_lc      <= lc_s;
      out_ca      <= ca_s;
      out_cb      <= cb_s;
      out_cc      <= cc_s;
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

// File: hdl/icp_det.sv
// ============================================================================
// icp_det: determinant sign (three register stages)
// Stage 4 splits each lifted-term by minor product into four partial
// products, stage 5 recombines each term, stage 6 sums the three terms and
// holds the sign as the result register.
// ============================================================================
`default_nettype none

module icp_det
  import icp_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_swapped,
  input  logic [2*COORD_WIDTH+1:0]        in_la,
  input  logic [2*COORD_WIDTH+1:0]        in_lb,
  input  logic [2*COORD_WIDTH+1:0]        in_lc,
  input  logic signed [2*COORD_WIDTH+2:0] in_ca,
  input  logic signed [2*COORD_WIDTH+2:0] in_cb,
  input  logic signed [2*COORD_WIDTH+2:0] in_cc,
  output logic                            out_valid,
  input  logic                            out_ready,
  output icp_result_t                     out_result
);

  localparam int W  = COORD_WIDTH;
  localparam int H  = W + 1;          // split point of both operands
  localparam int LW = 2 * H;          // lifted term width
  localparam int CW = 2 * W + 3;      // minor width
  localparam int HW = CW - H;         // signed upper part of a minor
  localparam int SW = H + 1 + HW;     // signed partial product width
  localparam int DW = 4 * W + 8;      // determinant width

  logic v4, v5, v6;
  logic ready4, ready5, ready6;

  logic [LW-1:0]        lv [3];
  logic signed [CW-1:0] cv [3];

  assign lv[0] = in_la;
  assign lv[1] = in_lb;
  assign lv[2] = in_lc;
  assign cv[0] = in_ca;
  assign cv[1] = in_cb;
  assign cv[2] = in_cc;

  assign ready6   = !v6 || out_ready;
  assign ready5   = !v5 || ready6;
  assign ready4   = !v4 || ready5;
  assign in_ready = ready4;

  // Stage 4: partial products
  logic [2*H-1:0]       p_ll [3];
  logic [2*H-1:0]       p_hl [3];
  logic signed [SW-1:0] p_lh [3];
  logic signed [SW-1:0] p_hh [3];
  logic                 s4_swapped;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      s4_swapped <= in_swapped;
      for (int k = 0; k < 3; k++) begin
        p_ll[k] <= LW'(lv[k][H-1:0]) * LW'(cv[k][H-1:0]);
        p_hl[k] <= LW'(lv[k][LW-1:H]) * LW'(cv[k][H-1:0]);
        p_lh[k] <= SW'($signed({1'b0, lv[k][H-1:0]}))
                 * SW'($signed(cv[k][CW-1:H]));
        p_hh[k] <= SW'($signed({1'b0, lv[k][LW-1:H]}))
                 * SW'($signed(cv[k][CW-1:H]));
      end
    end
  end

  // Stage 5: recombine each term
  logic signed [DW-1:0] term [3];
  logic                 s5_swapped;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (ready5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) begin
      s5_swapped <= s4_swapped;
      for (int k = 0; k < 3; k++) begin
        term[k] <= DW'($signed({1'b0, p_ll[k]}))
                 + (DW'($signed({1'b0, p_hl[k]})) <<< H)
                 + (DW'(p_lh[k]) <<< H)
                 + (DW'(p_hh[k]) <<< (2 * H));
      end
    end
  end

  // Stage 6: sum of terms and sign
  logic signed [DW-1:0] det;
  logic                 in_circle;

  assign det       = term[0] + term[1] + term[2];
  assign in_circle = !det[DW-1] && (det != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (ready6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ready6) begin
      out_result.passes       <= !in_circle;
      out_result.ends_swapped <= s5_swapped;
    end
  end

  assign out_valid = v6;

endmodule

`default_nettype wire

// File: hdl/incircle_predicate_top.sv
// ============================================================================
// incircle_predicate_top: Delaunay incircle test with edge reordering
// Orients the edge/candidate triangle counterclockwise, then takes the exact
// sign of the lifted incircle determinant for the probe point.
// ============================================================================
//
//  channel  | width            | content (lowest bits first)
//  ---------+------------------+---------------------------------------------
//  s_axis   | 8*COORD_WIDTH    | edge_start_x/y, edge_end_x/y, cand_x/y,
//           |                  | probe_x/y, each COORD_WIDTH bits signed
//  m_axis   | 8                | passes, ends_swapped, six zero bits
//
//  One transfer per cycle in and out while m_axis is not stalled; six register
//  stages (orientation products, reorder, lift/minors, partial products,
//  term recombine, final sum and sign).
//  Reset clears only the stage valid bits; data registers are not reset.
//  Each stage advances when empty or when the stage after it advances, so a
//  stall on m_axis backs up stage by stage and empty stages still fill.
//
`default_nettype none

module incircle_predicate_top
  import icp_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // edge_start_x, edge_start_y, edge_end_x, edge_end_y, cand_x, cand_y,
  // probe_x, probe_y
  input  logic [8*COORD_WIDTH-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // passes, ends_swapped, zero padding
  output logic [OUT_TDATA_W-1:0]     m_tdata
);

  localparam int W = COORD_WIDTH;

  // Orientation to lift
  logic              o_valid, o_ready, o_swapped;
  logic signed [W:0] o_ax, o_ay, o_bx, o_by, o_qx, o_qy;

  // Lift to determinant
  logic                  l_valid, l_ready, l_swapped;
  logic [2*W+1:0]        l_la, l_lb, l_lc;
  logic signed [2*W+2:0] l_ca, l_cb, l_cc;

  icp_result_t result;

  icp_orient #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_orient (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_coords   (s_tdata),
    .out_valid   (o_valid),
    .out_ready   (o_ready),
    .out_swapped (o_swapped),
    .out_ax      (o_ax),
    .out_ay      (o_ay),
    .out_bx      (o_bx),
    .out_by      (o_by),
    .out_qx      (o_qx),
    .out_qy      (o_qy)
  );

  icp_lift #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_lift (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (o_valid),
    .in_ready    (o_ready),
    .in_swapped  (o_swapped),
    .in_ax       (o_ax),
    .in_ay       (o_ay),
    .in_bx       (o_bx),
    .in_by       (o_by),
    .in_qx       (o_qx),
    .in_qy       (o_qy),
    .out_valid   (l_valid),
    .out_ready   (l_ready),
    .out_swapped (l_swapped),
    .out_la      (l_la),
    .out_lb      (l_lb),
    .out_lc      (l_lc),
    .out_ca      (l_ca),
    .out_cb      (l_cb),
    .out_cc      (l_cc)
  );

  icp_det #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_det (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (l_valid),
    .in_ready   (l_ready),
    .in_swapped (l_swapped),
    .in_la      (l_la),
    .in_lb      (l_lb),
    .in_lc      (l_lc),
    .in_ca      (l_ca),
    .in_cb      (l_cb),
    .in_cc      (l_cc),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  // Pack the result flags into the output byte
  assign m_tdata = {{(OUT_TDATA_W - 2){1'b0}}, result.ends_swapped, result.passes};

`ifndef SYNTHESIS
  // An empty output register means every stage can advance
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  // Reset drains the pipeline
  assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // Padding bits of a result stay zero
  assert property (@(posedge clk) disable iff (rst)
                   m_tvalid |-> (m_tdata[OUT_TDATA_W-1:2] == '0))
    else $error("nonzero padding in result");
`endif

endmodule

`default_nettype wire
